@@ rtl/tpz_pkg.sv @@
// Shared constants, types and the shade ramp for the torus point plotter.
package tpz_pkg;

   localparam int COLUMNS   = 80;
   localparam int ROWS      = 22;
   localparam int CELLS     = 1760;
   localparam int FRAC_BITS = 14;

   localparam int CELL_W = 11;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   localparam int DEN_W  = 20;
   localparam int DIV_QW = 31;

   localparam logic [7:0] SPACE_CODE = 8'd32;
   localparam int         RAMP_TOP   = 11;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_PLOT  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] REG_SIN_TILT = 2'd0;
   localparam logic [1:0] REG_COS_TILT = 2'd1;
   localparam logic [1:0] REG_SIN_SPIN = 2'd2;
   localparam logic [1:0] REG_COS_SPIN = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic [15:0] depth;
      logic [7:0]  glyph;
   } cell_entry_type;

   function automatic logic [7:0] shade_glyph(input logic [3:0] idx);
      logic [7:0] g;
      case (idx)
         4'd0:    g = 8'h2E;
         4'd1:    g = 8'h2C;
         4'd2:    g = 8'h2D;
         4'd3:    g = 8'h7E;
         4'd4:    g = 8'h3A;
         4'd5:    g = 8'h3B;
         4'd6:    g = 8'h3D;
         4'd7:    g = 8'h21;
         4'd8:    g = 8'h2A;
         4'd9:    g = 8'h23;
         4'd10:   g = 8'h24;
         default: g = 8'h40;
      endcase
      return g;
   endfunction

endpackage

@@ rtl/tpz_div.sv @@
// Restoring divider: saturated quotient of 2^30 by a positive denominator, one bit a cycle.
module tpz_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tpz_pkg::DEN_W-1:0]     den,
   output logic [15:0]                   quo,
   output tpz_pkg::div_stat_type         stat
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [tpz_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [tpz_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [tpz_pkg::DIV_QW-1:0]    quo_ff, quo_in;
   logic [tpz_pkg::DEN_W:0]       rem_sh;
   logic                          ge;

   always_comb begin
      // dividend is a single one at bit 30
      rem_sh = {rem_ff, (cnt_ff == 5'(tpz_pkg::DIV_QW - 1))};
      ge     = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = 5'(tpz_pkg::DIV_QW - 1);
         rem_in  = '0;
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? tpz_pkg::DEN_W'(rem_sh - {1'b0, den_ff})
                     : rem_sh[tpz_pkg::DEN_W-1:0];
         quo_in = {quo_ff[tpz_pkg::DIV_QW-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo       = (|quo_ff[tpz_pkg::DIV_QW-1:16]) ? 16'hFFFF : quo_ff[15:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ rtl/tpz_ram.sv @@
// Frame memory: depth and glyph per cell, one write and one registered read a cycle.
module tpz_ram (
   input  logic                          clock,
   input  logic                          we,
   input  logic [tpz_pkg::CELL_W-1:0]    waddr,
   input  tpz_pkg::cell_entry_type       wdata,
   input  logic [tpz_pkg::CELL_W-1:0]    raddr,
   output tpz_pkg::cell_entry_type       rdata
);

   tpz_pkg::cell_entry_type mem_ff [tpz_pkg::CELLS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ rtl/torus_point_zbuffer_plotter_unit.sv @@
// Top level of the torus point plotter: sequencer, shared multiplier, divider and frame memory.
//
// Usage:
//   req_* carries one action (clear, plot, read) per transfer; rsp_* returns exactly one
//   result per action. csr_* writes the tilt and spin sines and cosines (index 0..3)
//   and must only be written while the block is idle.
//   A plot runs 17 fixed-point products on one shared multiplier, each through a multiply
//   and an accumulate state, and waits for the divider that forms the reciprocal depth
//   (it ends there when the denominator is not positive), then two more products for the
//   projection, a projection step, a cell step, a memory read and a depth compare; a point
//   outside the frame skips the read and the compare. A read goes through a memory read;
//   one past the frame, or the unused action, goes straight to the result.
//   A clear sweeps the whole frame memory one cell a cycle.
//   One item is in work at a time; req_ready is high only between items and rises
//   with the result. After reset the same sweep fills the memory with empty cells before
//   req_ready rises; configuration writes are taken during it.
//   The result sits in an output register; while the receiver stalls it holds, and
//   the block takes the next item, finishing its work up to the point of delivery.
module torus_point_zbuffer_plotter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic signed [15:0]            req_sin_theta,
   input  logic signed [15:0]            req_cos_theta,
   input  logic signed [15:0]            req_sin_phi,
   input  logic signed [15:0]            req_cos_phi,
   input  logic [10:0]                   req_read_cell,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_glyph,
   output logic [10:0]                   rsp_cell_res,
   output logic                          rsp_drawn,
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_wdata
);

   typedef enum logic [8:0] {
      ST_SWEEP = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_MUL   = 9'b000000100,
      ST_ACC   = 9'b000001000,
      ST_DIVW  = 9'b000010000,
      ST_PROJ  = 9'b000100000,
      ST_CELL  = 9'b001000000,
      ST_RD    = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   localparam int S = tpz_pkg::FRAC_BITS;
   localparam logic signed [23:0] ONE_2 = 24'sd2 <<< S;
   localparam logic signed [23:0] ONE_5 = 24'sd5 <<< S;
   localparam logic signed [45:0] COL_BASE = 46'sd40 <<< 30;
   localparam logic signed [45:0] ROW_BASE = 46'sd12 <<< 30;
   localparam logic signed [45:0] TRUNC_ADJ = (46'sd1 <<< 30) - 46'sd1;

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;

   logic signed [15:0] sin_tilt_ff, cos_tilt_ff, sin_spin_ff, cos_spin_ff;
   logic signed [15:0] st_ff, ct_ff, sp_ff, cp_ff;
   logic signed [17:0] h_ff;
   logic signed [23:0] sh_ff, den_ff, t_ff, a_ff, ch_ff, u_ff, w_ff, spc_ff, lum_ff, tmp_ff;
   logic signed [41:0] prod_ff, du_ff, dw_ff;
   logic               den_ok_ff;
   logic [15:0]        d_ff;

   logic [tpz_pkg::COL_W-1:0]  col_ff;
   logic [tpz_pkg::ROW_W-1:0]  row_ff;
   logic                       inb_ff;
   logic [tpz_pkg::CELL_W-1:0] cell_ff;
   logic                       is_plot_ff;
   logic                       clear_job_ff;
   logic [tpz_pkg::CELL_W-1:0] sweep_ff;
   logic                       look_ff;
   logic                       look_write;

   logic [7:0]  res_glyph_ff;
   logic [10:0] res_cell_ff;
   logic        res_drawn_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_glyph_ff;
   logic [10:0] rsp_cell_ff;
   logic        rsp_drawn_ff;

   logic signed [23:0] a_sel;
   logic signed [17:0] b_sel;
   logic signed [23:0] r;
   logic signed [23:0] den_nx;
   logic               div_start;
   logic [15:0]        div_quo;
   tpz_pkg::div_stat_type div_stat;

   logic                       ram_we;
   logic [tpz_pkg::CELL_W-1:0] ram_waddr;
   tpz_pkg::cell_entry_type    ram_wdata;
   tpz_pkg::cell_entry_type    ram_rdata;

   logic signed [45:0] col_sum, row_sum;
   logic signed [15:0] col_q, row_q;
   logic [15:0]        cell_sum;
   logic [3:0]         shade_idx;
   logic               nearer;
   logic               accept;
   logic               fin_load;

   function automatic logic signed [15:0] trunc30(input logic signed [45:0] v);
      logic signed [45:0] adj;
      adj = (v < 0) ? v + TRUNC_ADJ : v;
      return adj[45:30];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // operand select for the shared multiplier
   always_comb begin
      a_sel = 24'(sp_ff);
      b_sel = h_ff;
      case (step_ff)
         5'd0:    begin a_sel = 24'(sp_ff);  b_sel = h_ff;                end
         5'd1:    begin a_sel = sh_ff;       b_sel = 18'(sin_tilt_ff);    end
         5'd2:    begin a_sel = 24'(st_ff);  b_sel = 18'(cos_tilt_ff);    end
         5'd3:    begin a_sel = sh_ff;       b_sel = 18'(cos_tilt_ff);    end
         5'd4:    begin a_sel = 24'(st_ff);  b_sel = 18'(sin_tilt_ff);    end
         5'd5:    begin a_sel = 24'(cp_ff);  b_sel = h_ff;                end
         5'd6:    begin a_sel = ch_ff;       b_sel = 18'(cos_spin_ff);    end
         5'd7:    begin a_sel = t_ff;        b_sel = 18'(sin_spin_ff);    end
         5'd8:    begin a_sel = ch_ff;       b_sel = 18'(sin_spin_ff);    end
         5'd9:    begin a_sel = t_ff;        b_sel = 18'(cos_spin_ff);    end
         5'd10:   begin a_sel = 24'(sp_ff);  b_sel = 18'(ct_ff);          end
         5'd11:   begin a_sel = spc_ff;      b_sel = 18'(cos_tilt_ff);    end
         5'd12:   begin a_sel = lum_ff;      b_sel = 18'(cos_spin_ff);    end
         5'd13:   begin a_sel = spc_ff;      b_sel = 18'(sin_tilt_ff);    end
         5'd14:   begin a_sel = 24'(st_ff);  b_sel = 18'(cos_tilt_ff);    end
         5'd15:   begin a_sel = 24'(cp_ff);  b_sel = 18'(ct_ff);          end
         5'd16:   begin a_sel = tmp_ff;      b_sel = 18'(sin_spin_ff);    end
         5'd17:   begin a_sel = u_ff;        b_sel = $signed({2'b00, d_ff}); end
         5'd18:   begin a_sel = w_ff;        b_sel = $signed({2'b00, d_ff}); end
         default: begin a_sel = 24'(sp_ff);  b_sel = h_ff;                end
      endcase
   end

   // product rounded toward minus infinity back to S fraction bits
   assign r         = prod_ff[S+23:S];
   assign den_nx    = den_ff + r + ONE_5;
   assign div_start = (state_ff == ST_ACC) && (step_ff == 5'd2) && (den_nx > 0);

   tpz_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   (den_nx[tpz_pkg::DEN_W-1:0]),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   // projection: 30*du and 15*dw by shift and subtract
   assign col_sum = COL_BASE + ((46'(du_ff) <<< 5) - (46'(du_ff) <<< 1));
   assign row_sum = ROW_BASE + ((46'(dw_ff) <<< 4) - 46'(dw_ff));
   assign col_q   = trunc30(col_sum);
   assign row_q   = trunc30(row_sum);
   assign cell_sum = 16'(col_ff) + 16'(tpz_pkg::COLUMNS) * 16'(row_ff);

   // negative luminance clamps to the first glyph, large values to the last
   always_comb begin
      if (lum_ff < 0) begin
         shade_idx = 4'd0;
      end else if (lum_ff[23:S-3] > (27-S)'(tpz_pkg::RAMP_TOP)) begin
         shade_idx = 4'(tpz_pkg::RAMP_TOP);
      end else begin
         shade_idx = lum_ff[S:S-3];
      end
   end

   assign nearer = d_ff > ram_rdata.depth;

   assign look_write = look_ff && is_plot_ff && nearer;
   assign ram_we     = (state_ff == ST_SWEEP) || look_write;
   assign ram_waddr  = (state_ff == ST_SWEEP) ? sweep_ff : cell_ff;
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         ram_wdata.depth = 16'd0;
         ram_wdata.glyph = tpz_pkg::SPACE_CODE;
      end else begin
         ram_wdata.depth = d_ff;
         ram_wdata.glyph = tpz_pkg::shade_glyph(shade_idx);
      end
   end

   tpz_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cell_ff),
      .rdata (ram_rdata)
   );

   assign fin_load = (state_ff == ST_FIN) && !look_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_ff == tpz_pkg::CELL_W'(tpz_pkg::CELLS - 1)) begin
               state_in = clear_job_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               step_in = 5'd0;
               case (req_action)
                  tpz_pkg::ACT_CLEAR: state_in = ST_SWEEP;
                  tpz_pkg::ACT_PLOT:  state_in = ST_MUL;
                  tpz_pkg::ACT_READ:  state_in = (req_read_cell < 11'(tpz_pkg::CELLS)) ?
                                                 ST_RD : ST_FIN;
                  default:            state_in = ST_FIN;
               endcase
            end
         end
         ST_MUL:  state_in = ST_ACC;
         ST_ACC: begin
            if (step_ff == 5'd16) begin
               state_in = ST_DIVW;
            end else if (step_ff == 5'd18) begin
               state_in = ST_PROJ;
            end else begin
               step_in  = step_ff + 5'd1;
               state_in = ST_MUL;
            end
         end
         ST_DIVW: begin
            if (!den_ok_ff) begin
               state_in = ST_FIN;
            end else if (div_stat.done) begin
               step_in  = 5'd17;
               state_in = ST_MUL;
            end
         end
         ST_PROJ: state_in = ST_CELL;
         ST_CELL: begin
            if (inb_ff && cell_sum < 16'(tpz_pkg::CELLS)) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_RD:   state_in = ST_FIN;
         ST_FIN: begin
            if (fin_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         step_ff      <= 5'd0;
         sweep_ff     <= '0;
         clear_job_ff <= 1'b0;
         look_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sin_tilt_ff  <= 16'sd0;
         cos_tilt_ff  <= 16'sd16384;
         sin_spin_ff  <= 16'sd0;
         cos_spin_ff  <= 16'sd16384;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         look_ff  <= (state_ff == ST_RD);
         if (state_ff == ST_SWEEP) begin
            sweep_ff <= (sweep_ff == tpz_pkg::CELL_W'(tpz_pkg::CELLS - 1)) ?
                        '0 : sweep_ff + tpz_pkg::CELL_W'(1);
         end
         if (accept) begin
            clear_job_ff <= (req_action == tpz_pkg::ACT_CLEAR);
         end
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            case (csr_index)
               tpz_pkg::REG_SIN_TILT: sin_tilt_ff <= csr_wdata;
               tpz_pkg::REG_COS_TILT: cos_tilt_ff <= csr_wdata;
               tpz_pkg::REG_SIN_SPIN: sin_spin_ff <= csr_wdata;
               default:               cos_spin_ff <= csr_wdata;
            endcase
         end
      end
   end

   // datapath and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         st_ff        <= req_sin_theta;
         ct_ff        <= req_cos_theta;
         sp_ff        <= req_sin_phi;
         cp_ff        <= req_cos_phi;
         h_ff         <= 18'(req_cos_theta) + 18'(ONE_2);
         is_plot_ff   <= (req_action == tpz_pkg::ACT_PLOT);
         cell_ff      <= req_read_cell;
         res_glyph_ff <= (req_action == tpz_pkg::ACT_CLEAR ||
                          req_action == tpz_pkg::ACT_PLOT ||
                          req_action == tpz_pkg::ACT_READ) ? tpz_pkg::SPACE_CODE : 8'd0;
         res_cell_ff  <= (req_action == tpz_pkg::ACT_READ) ? req_read_cell : 11'd0;
         res_drawn_ff <= 1'b0;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= a_sel * b_sel;
      end
      if (state_ff == ST_ACC) begin
         case (step_ff)
            5'd0:    sh_ff  <= r;
            5'd1:    den_ff <= r;
            5'd2: begin
               den_ff    <= den_nx;
               den_ok_ff <= den_nx > 0;
            end
            5'd3:    t_ff   <= r;
            5'd4: begin
               t_ff <= t_ff - r;
               a_ff <= r;
            end
            5'd5:    ch_ff  <= r;
            5'd6:    u_ff   <= r;
            5'd7:    u_ff   <= u_ff - r;
            5'd8:    w_ff   <= r;
            5'd9:    w_ff   <= w_ff + r;
            5'd10:   spc_ff <= r;
            5'd11:   lum_ff <= a_ff - r;
            5'd12:   lum_ff <= r;
            5'd15:   tmp_ff <= r;
            5'd17:   du_ff  <= prod_ff;
            5'd18:   dw_ff  <= prod_ff;
            default: lum_ff <= lum_ff - r;
         endcase
      end
      if (state_ff == ST_DIVW && div_stat.done) begin
         d_ff <= div_quo;
      end
      if (state_ff == ST_PROJ) begin
         col_ff <= col_q[tpz_pkg::COL_W-1:0];
         row_ff <= row_q[tpz_pkg::ROW_W-1:0];
         inb_ff <= (col_q > 0) && (col_q < 16'(tpz_pkg::COLUMNS)) &&
                   (row_q > 0) && (row_q < 16'(tpz_pkg::ROWS));
      end
      if (state_ff == ST_CELL) begin
         cell_ff <= cell_sum[tpz_pkg::CELL_W-1:0];
      end
      if (look_ff) begin
         res_cell_ff <= cell_ff;
         if (is_plot_ff && nearer) begin
            res_glyph_ff <= tpz_pkg::shade_glyph(shade_idx);
            res_drawn_ff <= 1'b1;
         end else begin
            res_glyph_ff <= ram_rdata.glyph;
         end
      end
      if (fin_load) begin
         rsp_glyph_ff <= res_glyph_ff;
         rsp_cell_ff  <= res_cell_ff;
         rsp_drawn_ff <= res_drawn_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_glyph    = rsp_glyph_ff;
   assign rsp_cell_res = rsp_cell_ff;
   assign rsp_drawn    = rsp_drawn_ff;

`ifndef SYNTHESIS
   a_we_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_SWEEP || look_ff))
      else $error("frame write outside sweep or depth update");
   a_proj_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROJ |-> $past(state_ff) == ST_ACC)
      else $error("projection entered without product");
   a_drawn_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_drawn_ff |-> rsp_glyph_ff != tpz_pkg::SPACE_CODE)
      else $error("drawn point reports empty glyph");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_stat.busy)
      else $error("divider busy while idle");
`endif

endmodule
